@@ rtl/swsr_pkg.sv @@
// Shared types and constants of the sliding window sender.
package swsr_pkg;

	localparam int SEG_W  = 12;
	localparam int RTO_W  = 12;
	localparam int EST_W  = 18;
	localparam int SUM_W  = 20;

	// Largest transfer in segments; the segment fields are sized for it.
	localparam int MAX_SEGMENTS = 2048;

	localparam logic [RTO_W-1:0] RTO_LOW     = 12'd1000;
	localparam logic [RTO_W-1:0] RTO_HIGH    = 12'd3000;
	localparam logic [3:0]       RETRY_LIMIT = 4'd12;
	localparam logic [1:0]       DUP_THRESH  = 2'd3;
	localparam logic [EST_W-1:0] DEV_INIT    = 18'd750;
	localparam logic [12:0]      ACK_NONE    = 13'h1FFF;
	localparam logic [5:0]       WLIMIT_RST  = 6'd8;

	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_WINDOW = 2'd0,
		KIND_RETX   = 2'd1,
		KIND_NONE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		RUN_ACTIVE = 2'd0,
		RUN_FIN    = 2'd1,
		RUN_ABORT  = 2'd2
	} run_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_EST1,
		F_EST2,
		F_EST3,
		F_CMD
	} front_state_t;

	// One event's worth of work for the emitter.
	typedef struct packed {
		logic             retx;
		logic             resend;
		logic [SEG_W-1:0] base;
		logic [SEG_W-1:0] from;
		logic [SEG_W-1:0] upto;
		logic [1:0]       status;
		logic [RTO_W-1:0] rto;
	} cmd_t;

endpackage

@@ rtl/swsr_queue.sv @@
// Two-entry command queue between the event front end and the emitter.
module swsr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swsr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output swsr_pkg::cmd_t pop_cmd
);
	swsr_pkg::cmd_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end
endmodule

@@ rtl/swsr_front.sv @@
// Event front end: RTT estimator, window and congestion state, command build.
module swsr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    op,
	input  logic [11:0]   total_segments,
	input  logic [11:0]   ack_number,
	input  logic [15:0]   receiver_window,
	input  logic          fin_flag,
	input  logic [15:0]   rtt_sample_ms,
	input  logic          cfg_we,
	input  logic [5:0]    cfg_wdata,
	output logic          q_push,
	output swsr_pkg::cmd_t q_cmd,
	input  logic          q_full
);
	swsr_pkg::front_state_t state_q, state_d;

	logic [1:0]  op_q;
	logic [11:0] total_q, ack_q;
	logic [15:0] rwin_in_q, rtt_q;
	logic        fin_q;

	logic [5:0]  wl_q;
	logic [11:0] cnt_q, base_q, nts_q, hi_q;
	logic        rsnd_q;
	logic [15:0] cwnd_q, ssth_q, rwnd_q;
	logic signed [17:0] srtt_q, dev_q, d_q;
	logic [11:0] rto_q;
	logic [3:0]  retry_q;
	logic [1:0]  dup_q;
	logic [12:0] prev_q;
	logic [1:0]  run_q;

	// Estimator arithmetic.
	logic signed [17:0] d8, ad, e, e4;
	logic signed [19:0] rsum;

	// Next state computed in the command cycle.
	logic [11:0] cnt_n, base_n, nts_n, hi_n;
	logic        rsnd_n;
	logic [15:0] cwnd_n, ssth_n, rwnd_n, budget;
	logic [11:0] rto_n;
	logic [3:0]  retry_n;
	logic [1:0]  dup_n;
	logic [12:0] prev_n;
	logic [1:0]  run_n;
	logic        go, retx;
	logic [16:0] cwnd_inc;
	logic [12:0] rto2;
	logic [11:0] nts0, from, lim;
	logic [12:0] wend;
	logic        resend, wsend;

	assign in_ready = (state_q == swsr_pkg::F_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= swsr_pkg::F_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		q_push  = 1'b0;
		unique case (state_q)
			swsr_pkg::F_IDLE: begin
				if (in_valid) begin
					if (op == swsr_pkg::OP_ACK && run_q == swsr_pkg::RUN_ACTIVE)
						state_d = swsr_pkg::F_EST1;
					else
						state_d = swsr_pkg::F_CMD;
				end
			end
			swsr_pkg::F_EST1: state_d = swsr_pkg::F_EST2;
			swsr_pkg::F_EST2: state_d = swsr_pkg::F_EST3;
			swsr_pkg::F_EST3: state_d = swsr_pkg::F_CMD;
			swsr_pkg::F_CMD: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = swsr_pkg::F_IDLE;
				end
			end
			default: state_d = swsr_pkg::F_IDLE;
		endcase
	end

	// Divisions truncate toward zero, so negative values are biased first.
	always_comb begin
		d8   = (d_q + (d_q < 0 ? 18'sd7 : 18'sd0)) >>> 3;
		ad   = (d_q < 0) ? -d_q : d_q;
		e    = ad - dev_q;
		e4   = (e + (e < 0 ? 18'sd3 : 18'sd0)) >>> 2;
		rsum = 20'(srtt_q) + (20'(dev_q) <<< 2);
	end

	always_comb begin
		cnt_n   = cnt_q;
		base_n  = base_q;
		nts_n   = nts_q;
		hi_n    = hi_q;
		rsnd_n  = rsnd_q;
		cwnd_n  = cwnd_q;
		ssth_n  = ssth_q;
		rwnd_n  = rwnd_q;
		rto_n   = rto_q;
		retry_n = retry_q;
		dup_n   = dup_q;
		prev_n  = prev_q;
		run_n   = run_q;
		go      = 1'b0;
		retx    = 1'b0;
		budget  = 16'd0;
		cwnd_inc = (cwnd_q > ssth_q) ? 17'(cwnd_q) + 17'd1 : {cwnd_q, 1'b0};
		rto2    = {rto_q, 1'b0};

		priority if (op_q == swsr_pkg::OP_START) begin
			cnt_n   = (int'(total_q) > swsr_pkg::MAX_SEGMENTS) ?
				12'(swsr_pkg::MAX_SEGMENTS) : total_q;
			base_n  = '0;
			nts_n   = '0;
			hi_n    = '0;
			rsnd_n  = 1'b0;
			cwnd_n  = 16'd1;
			ssth_n  = {11'd0, wl_q[5:1]};
			rwnd_n  = 16'd1;
			rto_n   = swsr_pkg::RTO_HIGH;
			retry_n = '0;
			dup_n   = '0;
			prev_n  = swsr_pkg::ACK_NONE;
			run_n   = swsr_pkg::RUN_ACTIVE;
			budget  = 16'd1;
			go      = 1'b1;
		end else if (op_q == swsr_pkg::OP_ACK && run_q == swsr_pkg::RUN_ACTIVE) begin
			retry_n = '0;
			if (rsum < 20'sd1000) rto_n = swsr_pkg::RTO_LOW;
			else if (rsum > 20'sd3000) rto_n = swsr_pkg::RTO_HIGH;
			else rto_n = rsum[11:0];
			if (fin_q) begin
				run_n = swsr_pkg::RUN_FIN;
			end else begin
				rwnd_n = rwin_in_q;
				if (base_q < ack_q) begin
					cwnd_n = cwnd_inc[16] ? 16'hFFFF : cwnd_inc[15:0];
					// Entries from the base up to the high mark are unacked unless
					// the base was marked for resend by a timeout.
					if (!rsnd_q && base_q < hi_q) begin
						base_n = (ack_q < hi_q) ? ack_q : hi_q;
						dup_n  = 2'd1;
						prev_n = {1'b0, ack_q};
					end
				end else if (base_q == ack_q) begin
					dup_n = ({1'b0, ack_q} == prev_q) ? dup_q + 2'd1 : dup_q;
					if (dup_n >= swsr_pkg::DUP_THRESH) begin
						retx  = (base_q < cnt_q);
						dup_n = '0;
					end
				end
				budget = (rwnd_n < cwnd_n) ? rwnd_n : cwnd_n;
				budget = (budget < 16'(wl_q)) ? budget : 16'(wl_q);
				go     = 1'b1;
			end
		end else if (op_q == swsr_pkg::OP_TIMEOUT && run_q == swsr_pkg::RUN_ACTIVE) begin
			rto_n   = (rto2 > 13'(swsr_pkg::RTO_HIGH)) ? swsr_pkg::RTO_HIGH : rto2[11:0];
			retry_n = retry_q + 4'd1;
			if (retry_n > swsr_pkg::RETRY_LIMIT) begin
				run_n = swsr_pkg::RUN_ABORT;
			end else begin
				nts_n  = base_q;
				rsnd_n = (base_q < hi_q);
				ssth_n = {1'b0, cwnd_q[15:1]};
				cwnd_n = 16'd1;
				budget = (rwnd_q != 16'd0 && wl_q != 6'd0) ? 16'd1 : 16'd0;
				go     = 1'b1;
			end
		end else begin
			go = 1'b0;
		end

		nts0   = (nts_n < base_n) ? base_n : nts_n;
		wend   = 13'(base_n) + 13'(budget[6:0]);
		lim    = (wend < 13'(cnt_n)) ? wend[11:0] : cnt_n;
		from   = (nts0 < hi_n) ? hi_n : nts0;
		resend = go && run_n == swsr_pkg::RUN_ACTIVE && rsnd_n && nts0 == base_n
			&& base_n < lim;
		wsend  = go && run_n == swsr_pkg::RUN_ACTIVE && from < lim;
		if (go && run_n == swsr_pkg::RUN_ACTIVE) begin
			nts_n = (nts0 < lim) ? lim : nts0;
			if (resend) rsnd_n = 1'b0;
			if (wsend) hi_n = lim;
		end

		q_cmd.retx   = retx;
		q_cmd.resend = resend;
		q_cmd.base   = base_n;
		q_cmd.from   = from;
		q_cmd.upto   = wsend ? lim : from;
		q_cmd.status = run_n;
		q_cmd.rto    = rto_n;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q      <= op;
			total_q   <= total_segments;
			ack_q     <= ack_number;
			rwin_in_q <= receiver_window;
			fin_q     <= fin_flag;
			rtt_q     <= rtt_sample_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= swsr_pkg::WLIMIT_RST;
			cnt_q   <= '0;
			base_q  <= '0;
			nts_q   <= '0;
			hi_q    <= '0;
			rsnd_q  <= 1'b0;
			cwnd_q  <= 16'd1;
			ssth_q  <= {11'd0, swsr_pkg::WLIMIT_RST[5:1]};
			rwnd_q  <= 16'd1;
			srtt_q  <= '0;
			dev_q   <= swsr_pkg::DEV_INIT;
			d_q     <= '0;
			rto_q   <= swsr_pkg::RTO_HIGH;
			retry_q <= '0;
			dup_q   <= '0;
			prev_q  <= swsr_pkg::ACK_NONE;
			run_q   <= swsr_pkg::RUN_ACTIVE;
		end else begin
			if (cfg_we) wl_q <= cfg_wdata;
			if (state_q == swsr_pkg::F_EST1)
				d_q <= $signed({2'b00, rtt_q}) - srtt_q;
			if (state_q == swsr_pkg::F_EST2) begin
				srtt_q <= srtt_q + d8;
				dev_q  <= dev_q + e4;
			end
			if (q_push) begin
				if (op_q == swsr_pkg::OP_START) begin
					srtt_q <= '0;
					dev_q  <= swsr_pkg::DEV_INIT;
				end
				cnt_q   <= cnt_n;
				base_q  <= base_n;
				nts_q   <= nts_n;
				hi_q    <= hi_n;
				rsnd_q  <= rsnd_n;
				cwnd_q  <= cwnd_n;
				ssth_q  <= ssth_n;
				rwnd_q  <= rwnd_n;
				rto_q   <= rto_n;
				retry_q <= retry_n;
				dup_q   <= dup_n;
				prev_q  <= prev_n;
				run_q   <= run_n;
			end
		end
	end
endmodule

@@ rtl/swsr_back.sv @@
// Emitter: turns one command into its sequence of result transactions.
module swsr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  swsr_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [10:0]   segment_number,
	output logic [1:0]    send_kind,
	output logic [1:0]    transfer_status,
	output logic [11:0]   timeout_ms,
	output logic          last
);
	logic        busy_q, rx_q, rb_q, vld_q;
	logic [11:0] pos_q, upto_q, base_q, rto_q;
	logic [1:0]  status_q;
	logic        advance, more;
	logic [10:0] seg_d;
	logic [1:0]  kind_d;
	logic        last_d;

	assign q_pop     = !busy_q && !q_empty;
	assign advance   = busy_q && (!vld_q || out_ready);
	assign out_valid = vld_q;
	assign more      = pos_q < upto_q;

	always_comb begin
		seg_d  = '0;
		kind_d = swsr_pkg::KIND_NONE;
		last_d = 1'b1;
		priority if (rx_q) begin
			seg_d  = base_q[10:0];
			kind_d = swsr_pkg::KIND_RETX;
			last_d = !(rb_q || more);
		end else if (rb_q) begin
			seg_d  = base_q[10:0];
			kind_d = swsr_pkg::KIND_WINDOW;
			last_d = !more;
		end else if (more) begin
			seg_d  = pos_q[10:0];
			kind_d = swsr_pkg::KIND_WINDOW;
			last_d = (pos_q + 12'd1 == upto_q);
		end else begin
			seg_d  = '0;
			kind_d = swsr_pkg::KIND_NONE;
			last_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_q  <= 1'b0;
			rx_q   <= 1'b0;
			rb_q   <= 1'b0;
		end else begin
			if (out_ready) vld_q <= 1'b0;
			if (q_pop) begin
				busy_q <= 1'b1;
				rx_q   <= q_cmd.retx;
				rb_q   <= q_cmd.resend;
			end else if (advance) begin
				vld_q <= 1'b1;
				if (rx_q) rx_q <= 1'b0;
				else if (rb_q) rb_q <= 1'b0;
				if (last_d) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pos_q    <= q_cmd.from;
			upto_q   <= q_cmd.upto;
			base_q   <= q_cmd.base;
			status_q <= q_cmd.status;
			rto_q    <= q_cmd.rto;
		end else if (advance) begin
			if (!rx_q && !rb_q && more) pos_q <= pos_q + 12'd1;
			segment_number  <= seg_d;
			send_kind       <= kind_d;
			transfer_status <= status_q;
			timeout_ms      <= rto_q;
			last            <= last_d;
		end
	end
endmodule

@@ rtl/sliding_window_sender_rto.sv @@
// Top level of the sliding window sender with retransmission timeout.
//
// Events arrive on the s_ channel: s_tuser carries the event kind (start,
// ack, timer expired) and s_tdata the segment count, ack number, receiver
// window, fin flag and RTT sample. Results leave on the m_ channel, one
// transaction per segment to send, m_tlast on the final one of an event;
// an event with nothing to send still gives one transaction.
// The window limit is to be written on the cfg channel only while the
// block is idle, which the block does not enforce. An active transfer's
// ack event takes three estimator steps before its command step, others
// none; the emitter loads each command, then gives one result per cycle
// while m_tready is high, up to 64 for one event. A two-entry command
// queue lets the front end take the next event while the emitter sends.
// Reset clears the transfer to zero segments, window limit 8, timeout 3000.
// When the receiver holds m_tready low the current result waits in the
// output register and the emitter, then the queue, then s_tready stall.
module sliding_window_sender_rto (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// total_segments[11:0], ack_number[23:12], receiver_window[39:24],
	// fin_flag[40], rtt_sample_ms[56:41], zero fill above
	input  logic [63:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// segment_number[10:0], transfer_status[12:11], timeout_ms[24:13], zero fill
	output logic [31:0] m_tdata,
	// send_kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	swsr_pkg::cmd_t push_cmd, pop_cmd;
	logic q_push, q_pop, q_full, q_empty;
	logic [10:0] seg;
	logic [1:0]  status;
	logic [11:0] rto;

	assign cfg_ready = 1'b1;

	swsr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.op              (s_tuser),
		.total_segments  (s_tdata[11:0]),
		.ack_number      (s_tdata[23:12]),
		.receiver_window (s_tdata[39:24]),
		.fin_flag        (s_tdata[40]),
		.rtt_sample_ms   (s_tdata[56:41]),
		.cfg_we          (cfg_valid),
		.cfg_wdata       (cfg_data),
		.q_push          (q_push),
		.q_cmd           (push_cmd),
		.q_full          (q_full)
	);

	swsr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_cmd  (pop_cmd)
	);

	swsr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_cmd           (pop_cmd),
		.q_pop           (q_pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.segment_number  (seg),
		.send_kind       (m_tuser),
		.transfer_status (status),
		.timeout_ms      (rto),
		.last            (m_tlast)
	);

	assign m_tdata = {7'd0, rto, status, seg};
endmodule
